// ===== hdl/direct_mapped_read_cache_unit_defines.svh =====
// Assertion macros shared by the cache controller and datapath.
// No dependencies; included by files that carry concurrent checks.
`ifndef DIRECT_MAPPED_READ_CACHE_UNIT_DEFINES_SVH
`define DIRECT_MAPPED_READ_CACHE_UNIT_DEFINES_SVH

// same-cycle implication
`define DMRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DMRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dmrc_pkg.sv =====
// Package for the direct-mapped read cache: default geometry, status codes,
// controller state type and the controller-to-datapath command struct.
`timescale 1ns / 1ps

package dmrc_pkg;

    localparam int LOG_CACHE_BYTES_DEF = 14;
    localparam int LOG_LINE_BYTES_DEF  = 7;
    localparam int POS_BITS_DEF        = 32;

    localparam logic [1:0] STATUS_HIT    = 2'd0;
    localparam logic [1:0] STATUS_MISS   = 2'd1;
    localparam logic [1:0] STATUS_FILLED = 2'd2;
    localparam logic [1:0] STATUS_ERROR  = 2'd3;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic fill_wr;
        logic fill_last;
        logic err;
    } cmd_t;

endpackage

// ===== hdl/dmrc_ctrl.sv =====
// Cache controller: lookup sequencing, fill tracking and protocol checks.
// Depends on dmrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "direct_mapped_read_cache_unit_defines.svh"

module dmrc_ctrl #(
    parameter int LOG_LINE_BYTES = dmrc_pkg::LOG_LINE_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      kind,
    input  logic                      hit,
    output logic                      busy,
    output dmrc_pkg::cmd_t            cmd,
    output logic [LOG_LINE_BYTES-1:0] fill_idx
);
    import dmrc_pkg::*;

    state_t                    state_reg, state_next;
    logic                      fill_pending_reg, fill_pending_next;
    logic [LOG_LINE_BYTES-1:0] fill_idx_reg, fill_idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_pending_reg <= 1'b0;
            fill_idx_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_pending_reg <= fill_pending_next;
            fill_idx_reg     <= fill_idx_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        fill_pending_next = fill_pending_reg;
        fill_idx_next     = fill_idx_reg;
        cmd               = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_READ)
                    begin
                        if (fill_pending_reg)
                            cmd.err = 1'b1;
                        else
                        begin
                            cmd.capture = 1'b1;
                            state_next  = ST_LOOKUP;
                        end
                    end
                    else
                    begin
                        if (!fill_pending_reg)
                            cmd.err = 1'b1;
                        else
                        begin
                            cmd.fill_wr = 1'b1;
                            if (fill_idx_reg == '1)
                            begin
                                cmd.fill_last     = 1'b1;
                                fill_pending_next = 1'b0;
                                fill_idx_next     = '0;
                            end
                            else
                                fill_idx_next = fill_idx_reg + 1'b1;
                        end
                    end
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_IDLE;
                if (!hit)
                begin
                    fill_pending_next = 1'b1;
                    fill_idx_next     = '0;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy     = (state_reg == ST_LOOKUP);
    assign fill_idx = fill_idx_reg;

    `DMRC_ASSERT_NEXT(a_lookup_one_cycle, clk, rst_n, busy, !busy, "lookup held past one cycle")
    `DMRC_ASSERT_NEXT(a_capture_to_lookup, clk, rst_n, cmd.capture, busy, "capture without lookup")
    `DMRC_ASSERT_NOW(a_last_needs_pending, clk, rst_n, cmd.fill_last, cmd.fill_wr && fill_pending_reg, "last fill without pending miss")

endmodule

// ===== hdl/dmrc_datapath.sv =====
// Cache datapath: tag and line memories, valid bits, position tracking
// and result registers. Depends on dmrc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "direct_mapped_read_cache_unit_defines.svh"

module dmrc_datapath #(
    parameter int LOG_CACHE_BYTES = dmrc_pkg::LOG_CACHE_BYTES_DEF,
    parameter int LOG_LINE_BYTES  = dmrc_pkg::LOG_LINE_BYTES_DEF,
    parameter int POS_BITS        = dmrc_pkg::POS_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dmrc_pkg::cmd_t            cmd,
    input  logic [LOG_LINE_BYTES-1:0] fill_idx,
    input  logic [POS_BITS-1:0]       position,
    input  logic [7:0]                fill_byte,
    output logic                      hit,
    output logic                      done,
    output logic [1:0]                status,
    output logic [7:0]                data_byte,
    output logic [POS_BITS-1:0]       fetch_start,
    output logic                      need_seek
);
    import dmrc_pkg::*;

    localparam int CACHE_BYTES = 1 << LOG_CACHE_BYTES;
    localparam int NUM_LINES   = 1 << (LOG_CACHE_BYTES - LOG_LINE_BYTES);
    localparam int LINE_BYTES  = 1 << LOG_LINE_BYTES;
    localparam int TAG_W       = POS_BITS - LOG_LINE_BYTES;
    localparam int LINE_W      = LOG_CACHE_BYTES - LOG_LINE_BYTES;

    logic [7:0]       data_mem [0:CACHE_BYTES-1];
    logic [TAG_W-1:0] tag_mem  [0:NUM_LINES-1];

    logic [NUM_LINES-1:0] valid_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [POS_BITS-1:0]  pend_pos_reg;
    logic [POS_BITS-1:0]  cur_pos_reg;
    logic [TAG_W-1:0]     tag_rd_reg;
    logic [7:0]           data_rd_reg;
    logic [7:0]           req_byte_reg;
    logic                 done_reg;
    logic [1:0]           status_reg;
    logic [7:0]           data_byte_reg;
    logic [POS_BITS-1:0]  fetch_start_reg;
    logic                 need_seek_reg;

    logic [LINE_W-1:0]          pos_line;
    logic [LINE_W-1:0]          pend_line;
    logic [POS_BITS-1:0]        pos_start;
    logic [POS_BITS-1:0]        pend_start;
    logic                       offset_match;
    logic [LOG_CACHE_BYTES-1:0] fill_addr;

    assign pos_line     = pos_reg[LOG_CACHE_BYTES-1:LOG_LINE_BYTES];
    assign pend_line    = pend_pos_reg[LOG_CACHE_BYTES-1:LOG_LINE_BYTES];
    assign pos_start    = {pos_reg[POS_BITS-1:LOG_LINE_BYTES], {LOG_LINE_BYTES{1'b0}}};
    assign pend_start   = {pend_pos_reg[POS_BITS-1:LOG_LINE_BYTES], {LOG_LINE_BYTES{1'b0}}};
    assign offset_match = (fill_idx == pend_pos_reg[LOG_LINE_BYTES-1:0]);
    assign fill_addr    = {pend_line, fill_idx};
    assign hit          = valid_reg[pos_line]
                          && (tag_rd_reg == pos_reg[POS_BITS-1:LOG_LINE_BYTES]);

    // line and tag storage, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            data_rd_reg <= data_mem[position[LOG_CACHE_BYTES-1:0]];
            tag_rd_reg  <= tag_mem[position[LOG_CACHE_BYTES-1:LOG_LINE_BYTES]];
        end
        if (cmd.fill_wr)
            data_mem[fill_addr] <= fill_byte;
        if (cmd.fill_last)
            tag_mem[pend_line] <= pend_pos_reg[POS_BITS-1:LOG_LINE_BYTES];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            pos_reg <= position;
        if (cmd.fill_wr && offset_match)
            req_byte_reg <= fill_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            pend_pos_reg <= '0;
            cur_pos_reg  <= '0;
        end
        else
        begin
            if (cmd.lookup && !hit)
                pend_pos_reg <= pos_reg;
            if (cmd.fill_last)
            begin
                valid_reg[pend_line] <= 1'b1;
                cur_pos_reg          <= pend_start + POS_BITS'(LINE_BYTES);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.lookup || cmd.fill_last || cmd.err;
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= STATUS_ERROR;
        data_byte_reg   <= '0;
        fetch_start_reg <= '0;
        need_seek_reg   <= 1'b0;
        if (cmd.lookup)
        begin
            if (hit)
            begin
                status_reg    <= STATUS_HIT;
                data_byte_reg <= data_rd_reg;
            end
            else
            begin
                status_reg      <= STATUS_MISS;
                fetch_start_reg <= pos_start;
                need_seek_reg   <= (pos_start != cur_pos_reg);
            end
        end
        else if (cmd.fill_last)
        begin
            status_reg    <= STATUS_FILLED;
            data_byte_reg <= offset_match ? fill_byte : req_byte_reg;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign data_byte   = data_byte_reg;
    assign fetch_start = fetch_start_reg;
    assign need_seek   = need_seek_reg;

    `DMRC_ASSERT_NEXT(a_lookup_result, clk, rst_n, cmd.lookup, done_reg, "lookup gave no result")
    `DMRC_ASSERT_NEXT(a_fill_marks_valid, clk, rst_n, cmd.fill_last, valid_reg[$past(pend_line)], "filled line not valid")

endmodule

// ===== hdl/direct_mapped_read_cache_unit.sv =====
// Direct-mapped byte read cache over a sequential backing store.
// Channels: a word is accepted when start is high and busy is low.
//   kind 0 reads the byte at position; kind 1 delivers the next fill byte.
// Results: one word per done pulse (status, data_byte, fetch_start, need_seek);
//   done is high for exactly one cycle and the receiver cannot hold it off.
// Read: busy is high for the one cycle after acceptance (tag and line memory
//   read, then tag compare); done is registered from the lookup state.
//   The tag/line memory read port is registered.
// Fill: accepted every cycle, written straight into the line memory. The last
//   fill of a line installs the tag, moves the store position to the line end
//   and pulses done in the cycle after its acceptance, with the requested byte.
// Miss: status miss with fetch_start; the user then sends one fill word per
//   line byte, in order. A read during a pending fill or a stray fill gives
//   status error, in the cycle after acceptance.
// Reset: asynchronous, clears all valid bits, the store position and fill
//   tracking at once; no clearing pass. Line data is only read after it was
//   written, so the memories need no reset.
// Depends on dmrc_pkg, dmrc_ctrl and dmrc_datapath.
`timescale 1ns / 1ps

module direct_mapped_read_cache_unit #(
    parameter int LOG_CACHE_BYTES = dmrc_pkg::LOG_CACHE_BYTES_DEF,
    parameter int LOG_LINE_BYTES  = dmrc_pkg::LOG_LINE_BYTES_DEF,
    parameter int POS_BITS        = dmrc_pkg::POS_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                kind,
    input  logic [POS_BITS-1:0] position,
    input  logic [7:0]          fill_byte,
    output logic                done,
    output logic [1:0]          status,
    output logic [7:0]          data_byte,
    output logic [POS_BITS-1:0] fetch_start,
    output logic                need_seek
);
    import dmrc_pkg::*;

    cmd_t                      cmd;
    logic                      hit;
    logic [LOG_LINE_BYTES-1:0] fill_idx;

    dmrc_ctrl #(
        .LOG_LINE_BYTES(LOG_LINE_BYTES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .kind    (kind),
        .hit     (hit),
        .busy    (busy),
        .cmd     (cmd),
        .fill_idx(fill_idx)
    );

    dmrc_datapath #(
        .LOG_CACHE_BYTES(LOG_CACHE_BYTES),
        .LOG_LINE_BYTES (LOG_LINE_BYTES),
        .POS_BITS       (POS_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .fill_idx   (fill_idx),
        .position   (position),
        .fill_byte  (fill_byte),
        .hit        (hit),
        .done       (done),
        .status     (status),
        .data_byte  (data_byte),
        .fetch_start(fetch_start),
        .need_seek  (need_seek)
    );

endmodule

// ===== verif/tb_direct_mapped_read_cache_unit.sv =====
// Testbench for direct_mapped_read_cache_unit: directed and random read/fill
// traffic, with every result word checked against an in-bench cache predictor.
// Depends on dmrc_pkg and the direct_mapped_read_cache_unit RTL.
`timescale 1ns / 1ps

module tb_direct_mapped_read_cache_unit;
    import dmrc_pkg::*;

    localparam int LINE_W     = LOG_LINE_BYTES_DEF;
    localparam int SLOT_W     = LOG_CACHE_BYTES_DEF;
    localparam int POS_W      = POS_BITS_DEF;
    localparam int TAG_W      = POS_W - LINE_W;
    localparam int HI_W       = POS_W - SLOT_W;
    localparam int LINES      = 1 << (SLOT_W - LINE_W);
    localparam int LINE_BYTES = 1 << LINE_W;
    localparam int CACHE_SIZE = 1 << SLOT_W;
    localparam int TARGET_ITEMS = 1050;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] position;
        logic [7:0]       fill_byte;
    } cache_cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       data_byte;
        logic [POS_W-1:0] fetch_start;
        logic             need_seek;
    } cache_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             kind = KIND_READ;
    logic [POS_W-1:0] position = '0;
    logic [7:0]       fill_byte = '0;
    logic             busy;
    logic             done;
    logic [1:0]       status;
    logic [7:0]       data_byte;
    logic [POS_W-1:0] fetch_start;
    logic             need_seek;

    direct_mapped_read_cache_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .kind       (kind),
        .position   (position),
        .fill_byte  (fill_byte),
        .done       (done),
        .status     (status),
        .data_byte  (data_byte),
        .fetch_start(fetch_start),
        .need_seek  (need_seek)
    );

    always #4 clk = ~clk;

    cache_cmd_t  pending_cmds[$];
    cache_word_t expected_words[$];
    int          mismatch_count = 0;
    int          sent_cmds = 0;
    int          total_cmds = 0;
    int          quiet_cycles = 0;
    logic        took_word = 1'b0;

    // predictor state
    bit               m_valid [LINES];
    logic [TAG_W-1:0] m_tag [LINES];
    logic [7:0]       m_bytes [CACHE_SIZE];
    logic [POS_W-1:0] m_cur = '0;
    bit               m_pend = 1'b0;
    logic [POS_W-1:0] m_pend_pos = '0;
    logic [LINE_W-1:0] m_idx = '0;

    // stimulus-side tracking of hits and misses
    bit               g_valid [LINES];
    logic [TAG_W-1:0] g_tag [LINES];
    logic [POS_W-1:0] g_cur = '0;
    bit               g_pend = 1'b0;
    logic [POS_W-1:0] g_pend_pos = '0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic predict_cache(input cache_cmd_t c, output bit produced,
                                 output cache_word_t w);
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-LINE_W-1:0] ln;
        logic [POS_W-1:0] base;
        w = '0;
        produced = 1'b1;
        if (c.kind == KIND_READ)
        begin
            slot = c.position[SLOT_W-1:0];
            ln = slot[SLOT_W-1:LINE_W];
            base = {c.position[POS_W-1:LINE_W], {LINE_W{1'b0}}};
            if (m_pend)
                w.status = STATUS_ERROR;
            else if (m_valid[ln] && m_tag[ln] == c.position[POS_W-1:LINE_W])
            begin
                w.status = STATUS_HIT;
                w.data_byte = m_bytes[slot];
            end
            else
            begin
                w.status = STATUS_MISS;
                w.fetch_start = base;
                w.need_seek = (base != m_cur);
                m_pend = 1'b1;
                m_pend_pos = c.position;
                m_idx = '0;
            end
        end
        else if (!m_pend)
            w.status = STATUS_ERROR;
        else
        begin
            slot = m_pend_pos[SLOT_W-1:0];
            ln = slot[SLOT_W-1:LINE_W];
            m_bytes[{ln, m_idx}] = c.fill_byte;
            if (m_idx != {LINE_W{1'b1}})
            begin
                m_idx = m_idx + 1'b1;
                produced = 1'b0;
            end
            else
            begin
                m_idx = '0;
                m_pend = 1'b0;
                m_valid[ln] = 1'b1;
                m_tag[ln] = m_pend_pos[POS_W-1:LINE_W];
                m_cur = {m_pend_pos[POS_W-1:LINE_W], {LINE_W{1'b0}}} + POS_W'(LINE_BYTES);
                w.status = STATUS_FILLED;
                w.data_byte = m_bytes[slot];
            end
        end
    endtask

    task automatic queue_read(input logic [POS_W-1:0] pos, output bit missed);
        cache_cmd_t c;
        logic [SLOT_W-LINE_W-1:0] ln;
        c.kind = KIND_READ;
        c.position = pos;
        c.fill_byte = 8'($urandom_range(255));
        pending_cmds.push_back(c);
        ln = pos[SLOT_W-1:LINE_W];
        missed = !g_pend && !(g_valid[ln] && g_tag[ln] == pos[POS_W-1:LINE_W]);
        if (missed)
        begin
            g_pend = 1'b1;
            g_pend_pos = pos;
        end
    endtask

    // one fill word per line byte, optionally with stray reads mixed in
    task automatic queue_line_fill(input int noise_pct);
        cache_cmd_t c;
        bit unused;
        logic [SLOT_W-LINE_W-1:0] ln;
        for (int i = 0; i < LINE_BYTES; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                queue_read($urandom, unused);
            c.kind = KIND_FILL;
            c.position = $urandom;
            case ($urandom_range(9))
                0: c.fill_byte = 8'h00;
                1: c.fill_byte = 8'hff;
                default: c.fill_byte = 8'($urandom_range(255));
            endcase
            pending_cmds.push_back(c);
        end
        ln = g_pend_pos[SLOT_W-1:LINE_W];
        g_valid[ln] = 1'b1;
        g_tag[ln] = g_pend_pos[POS_W-1:LINE_W];
        g_cur = {g_pend_pos[POS_W-1:LINE_W], {LINE_W{1'b0}}} + POS_W'(LINE_BYTES);
        g_pend = 1'b0;
    endtask

    always @(negedge clk)
    begin : driver
        cache_cmd_t c;
        int idle_pct;
        if (rst_n && (!start || took_word))
        begin
            if (sent_cmds < total_cmds / 3)
                idle_pct = 36;
            else if (sent_cmds < 2 * total_cmds / 3)
                idle_pct = 66;
            else
                idle_pct = 0;
            if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                c = pending_cmds.pop_front();
                kind <= c.kind;
                position <= c.position;
                fill_byte <= c.fill_byte;
                start <= 1'b1;
                sent_cmds++;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : monitor
        cache_cmd_t cmd;
        cache_word_t want;
        bit produced;
        if (rst_n)
        begin
            took_word <= start && !busy;
            if (done)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word, status %0d", status));
                else
                begin
                    want = expected_words.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  status, want.status));
                    if (data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte %02h, want %02h",
                                                  data_byte, want.data_byte));
                    if (fetch_start !== want.fetch_start)
                        report_mismatch($sformatf("fetch_start %08h, want %08h",
                                                  fetch_start, want.fetch_start));
                    if (need_seek !== want.need_seek)
                        report_mismatch($sformatf("need_seek %0b, want %0b",
                                                  need_seek, want.need_seek));
                end
            end
            if (start && !busy)
            begin
                cmd.kind = kind;
                cmd.position = position;
                cmd.fill_byte = fill_byte;
                predict_cache(cmd, produced, want);
                if (produced)
                    expected_words.push_back(want);
            end
            quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("direct_mapped_read_cache_unit verification failed");
        $finish;
    end

    initial
    begin : main
        cache_cmd_t c;
        bit missed;
        int n;
        int ops;
        logic [POS_W-1:0] pos;
        logic [HI_W-1:0] tag_pool [4];
        logic [SLOT_W-LINE_W-1:0] hot_base;
        logic [SLOT_W-LINE_W-1:0] ln;

        // directed: stray fill, miss, read during fill, hits, evictions, wrap
        c.kind = KIND_FILL;
        c.position = '1;
        c.fill_byte = 8'hff;
        pending_cmds.push_back(c);
        queue_read(32'h0000_0000, missed);
        queue_read(32'h0000_0005, missed);
        queue_line_fill(0);
        queue_read(32'h0000_0000, missed);
        queue_read(32'h0000_007f, missed);
        queue_read(32'h0000_0001, missed);
        queue_read(32'h0000_0080, missed);
        queue_line_fill(0);
        queue_read(32'h0000_4000, missed);
        queue_line_fill(0);
        queue_read(32'hffff_ffff, missed);
        queue_line_fill(0);
        queue_read(32'h0000_0003, missed);
        queue_line_fill(0);
        queue_read(32'hffff_ffc0, missed);
        queue_read(32'h0000_00ff, missed);
        c.fill_byte = 8'h00;
        c.position = '0;
        pending_cmds.push_back(c);

        // random: hot lines with a few tags each, sequential reads, noise
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = HI_W'($urandom);
        tag_pool[3] = HI_W'($urandom);
        hot_base = (SLOT_W - LINE_W)'($urandom_range(LINES - 1));
        ops = 0;
        while (pending_cmds.size() < TARGET_ITEMS - LINE_BYTES / 2)
        begin
            if (ops % 64 == 63)
                hot_base = (SLOT_W - LINE_W)'($urandom_range(LINES - 1));
            n = $urandom_range(99);
            if (n < 5)
            begin
                c.kind = KIND_FILL;
                c.position = $urandom;
                c.fill_byte = 8'($urandom_range(255));
                pending_cmds.push_back(c);
            end
            else
            begin
                if (n < 20)
                    pos = g_cur + $urandom_range(LINE_BYTES - 1);
                else if (n < 30)
                    pos = $urandom;
                else
                begin
                    if ($urandom_range(99) < 70)
                        ln = hot_base + 3'($urandom_range(7));
                    else
                        ln = (SLOT_W - LINE_W)'($urandom_range(LINES - 1));
                    pos = {tag_pool[$urandom_range(3)], ln,
                           LINE_W'($urandom_range(LINE_BYTES - 1))};
                end
                queue_read(pos, missed);
                if (missed)
                    queue_line_fill(($urandom_range(99) < 15) ? 4 : 0);
            end
            ops++;
        end
        total_cmds = pending_cmds.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        n = 0;
        while (expected_words.size() != 0 && n < 64)
        begin
            @(posedge clk);
            n++;
        end
        repeat (8) @(posedge clk);
        if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_words.size()));
        if (mismatch_count == 0)
            $display("direct_mapped_read_cache_unit verification clean");
        else
            $display("direct_mapped_read_cache_unit verification failed");
        $finish;
    end

endmodule
